// ----- rtl/hdcc_pkg.sv -----
// Shared types and constants for the HSV dominant color counter.
// Holds the pixel and result payload structs, the color box layout and the
// configuration register indexes. No dependencies.
package hdcc_pkg;

	// Block defaults
	localparam int NUM_COLORS_DEF = 4;
	localparam int COUNT_BITS_DEF = 16;

	// Configuration port geometry
	localparam int NUM_BOX_REGS = 4;
	localparam int BOX_IDX_BITS = 2;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS = 48;

	// Output count fields are fixed at 16 bits
	localparam int OUT_COUNT_BITS = 16;

	// Depth of the queue between classifier and counter back end
	localparam int QUEUE_DEPTH = 4;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_BOX0      = 3'd0,
		CFG_BOX1      = 3'd1,
		CFG_BOX2      = 3'd2,
		CFG_BOX3      = 3'd3,
		CFG_FIRST_ROW = 3'd4,
		CFG_END_ROW   = 3'd5,
		CFG_THRESHOLD = 3'd6
	} cfg_index_t;

	// One color box, lower bounds inclusive, upper bounds exclusive
	typedef struct packed {
		logic [7:0] val_max;
		logic [7:0] sat_max;
		logic [7:0] hue_max;
		logic [7:0] val_min;
		logic [7:0] sat_min;
		logic [7:0] hue_min;
	} box_t;

	// Reset boxes: yellow, black, light green, orange
	localparam box_t BOX0_RESET = 48'hFFFF_2350_3217;
	localparam box_t BOX1_RESET = 48'h3223_B400_0000;
	localparam box_t BOX2_RESET = 48'hFFFF_5064_5035;
	localparam box_t BOX3_RESET = 48'hFFFF_1650_320E;

	localparam logic [7:0]  FIRST_ROW_RESET = 8'd60;
	localparam logic [7:0]  END_ROW_RESET   = 8'd180;
	localparam logic [15:0] THRESHOLD_RESET = 16'd500;

	// Input transfer payload
	typedef struct packed {
		logic [7:0] hue;
		logic [7:0] saturation;
		logic [7:0] brightness;
		logic [7:0] row;
		logic       frame_end;
	} pixel_t;

	// Output transfer payload
	typedef struct packed {
		logic [1:0]                winner;
		logic [OUT_COUNT_BITS-1:0] winner_count;
		logic                      detected;
		logic [OUT_COUNT_BITS-1:0] count_a;
		logic [OUT_COUNT_BITS-1:0] count_b;
		logic [OUT_COUNT_BITS-1:0] count_c;
		logic [OUT_COUNT_BITS-1:0] count_d;
	} result_t;

endpackage

// ----- rtl/hdcc_front.sv -----
// Front end: accepts pixels, applies the row window and tests each color box.
// Pushes a hit vector plus the frame end mark into the queue.
// Depends on hdcc_pkg.
module hdcc_front #(
	parameter int NUM_COLORS = hdcc_pkg::NUM_COLORS_DEF
) (
	input  hdcc_pkg::pixel_t pixel,
	input  logic             pixel_valid,
	output logic             pixel_ready,
	input  hdcc_pkg::box_t   boxes [hdcc_pkg::NUM_BOX_REGS],
	input  logic [7:0]       first_row,
	input  logic [7:0]       end_row,
	input  logic             queue_full,
	output logic             push,
	output logic [NUM_COLORS-1:0] hits,
	output logic             frame_end
);

	logic in_window;

	function automatic logic in_box(hdcc_pkg::box_t b, logic [7:0] h, logic [7:0] s,
			logic [7:0] v);
		return (b.hue_min <= h) && (h < b.hue_max) &&
			(b.sat_min <= s) && (s < b.sat_max) &&
			(b.val_min <= v) && (v < b.val_max);
	endfunction

	// Accept whenever the queue has room
	assign pixel_ready = !queue_full;
	assign push        = pixel_valid && pixel_ready;
	assign frame_end   = pixel.frame_end;

	// Row window, end bound exclusive
	assign in_window = (pixel.row >= first_row) && (pixel.row < end_row);

	// Classify against each box; colors without a register never match
	for (genvar i = 0; i < NUM_COLORS; i++) begin : g_hit
		if (i < hdcc_pkg::NUM_BOX_REGS) begin : g_box
			assign hits[i] = in_window &&
				in_box(boxes[i], pixel.hue, pixel.saturation, pixel.brightness);
		end else begin : g_none
			assign hits[i] = 1'b0;
		end
	end

endmodule

// ----- rtl/hdcc_queue.sv -----
// Small FIFO that decouples the classifier from the counter back end.
// Register based, one write and one read per cycle.
// Depends on hdcc_pkg for the default depth.
module hdcc_queue #(
	parameter int DATA_BITS = 5,
	parameter int DEPTH     = hdcc_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [DATA_BITS-1:0] push_data,
	output logic                 full,
	output logic                 valid,
	input  logic                 pop,
	output logic [DATA_BITS-1:0] pop_data
);

	localparam int PTR_BITS  = $clog2(DEPTH);
	localparam int FILL_BITS = $clog2(DEPTH + 1);

	logic [DATA_BITS-1:0] entry_q [DEPTH];
	logic [PTR_BITS-1:0]  wr_ptr_q;
	logic [PTR_BITS-1:0]  rd_ptr_q;
	logic [FILL_BITS-1:0] fill_q;

	assign full     = (fill_q == FILL_BITS'(DEPTH));
	assign valid    = (fill_q != '0);
	assign pop_data = entry_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ----- rtl/hdcc_back.sv -----
// Back end: saturating color counters, frame snapshot, winner search and
// the output register. Depends on hdcc_pkg.
module hdcc_back #(
	parameter int NUM_COLORS = hdcc_pkg::NUM_COLORS_DEF,
	parameter int COUNT_BITS = hdcc_pkg::COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  queue_valid,
	input  logic [NUM_COLORS-1:0] queue_hits,
	input  logic                  queue_last,
	output logic                  queue_pop,
	input  logic [15:0]           threshold,
	output logic                  result_valid,
	input  logic                  result_ready,
	output hdcc_pkg::result_t     result
);

	localparam int IDX_BITS = (NUM_COLORS > 1) ? $clog2(NUM_COLORS) : 1;
	localparam int OCB      = hdcc_pkg::OUT_COUNT_BITS;

	logic [COUNT_BITS-1:0] count_q    [NUM_COLORS];
	logic [COUNT_BITS-1:0] next_count [NUM_COLORS];
	logic [COUNT_BITS-1:0] snap_s1    [NUM_COLORS];
	logic                  snap_valid_s1;
	logic                  snap_adv;
	logic                  snap_free;
	logic                  res_free;
	logic [COUNT_BITS-1:0] best;
	logic [IDX_BITS-1:0]   win_idx;
	logic [IDX_BITS+1:0]   win_ext;
	logic [OCB-1:0]        out_count [hdcc_pkg::NUM_BOX_REGS];
	logic [COUNT_BITS+OCB-1:0] best_ext;
	hdcc_pkg::result_t     result_q;
	logic                  result_valid_q;

	// Flow control: output register, then snapshot, then queue
	assign res_free  = !result_valid_q || result_ready;
	assign snap_adv  = snap_valid_s1 && res_free;
	assign snap_free = !snap_valid_s1 || snap_adv;
	assign queue_pop = queue_valid && (!queue_last || snap_free);

	// Saturating increment for every hit color
	always_comb begin
		for (int i = 0; i < NUM_COLORS; i++) begin
			if (queue_hits[i] && (count_q[i] != '1)) begin
				next_count[i] = count_q[i] + 1'b1;
			end else begin
				next_count[i] = count_q[i];
			end
		end
	end

	// Counters clear after the frame's last pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COLORS; i++) begin
				count_q[i] <= '0;
			end
		end else if (queue_pop) begin
			for (int i = 0; i < NUM_COLORS; i++) begin
				count_q[i] <= queue_last ? '0 : next_count[i];
			end
		end
	end

	// Snapshot the final counts of a frame
	always_ff @(posedge clk) begin
		if (queue_pop && queue_last) begin
			snap_s1 <= next_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s1 <= 1'b0;
		end else if (queue_pop && queue_last) begin
			snap_valid_s1 <= 1'b1;
		end else if (snap_adv) begin
			snap_valid_s1 <= 1'b0;
		end
	end

	// First strictly largest nonzero count wins
	always_comb begin
		best    = '0;
		win_idx = '0;
		for (int i = 0; i < NUM_COLORS; i++) begin
			if (snap_s1[i] > best) begin
				best    = snap_s1[i];
				win_idx = IDX_BITS'(i);
			end
		end
	end

	assign win_ext  = {2'b00, win_idx};
	assign best_ext = {{OCB{1'b0}}, best};

	// Trim counts to the output width; absent colors read zero
	for (genvar j = 0; j < hdcc_pkg::NUM_BOX_REGS; j++) begin : g_out
		if (j < NUM_COLORS) begin : g_have
			logic [COUNT_BITS+OCB-1:0] cnt_ext;
			assign cnt_ext      = {{OCB{1'b0}}, snap_s1[j]};
			assign out_count[j] = cnt_ext[OCB-1:0];
		end else begin : g_zero
			assign out_count[j] = '0;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (snap_adv) begin
			result_q.winner       <= win_ext[1:0];
			result_q.winner_count <= best_ext[OCB-1:0];
			result_q.detected     <= best_ext > {{COUNT_BITS{1'b0}}, threshold};
			result_q.count_a      <= out_count[0];
			result_q.count_b      <= out_count[1];
			result_q.count_c      <= out_count[2];
			result_q.count_d      <= out_count[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (snap_adv) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ----- rtl/hsv_dominant_color_counter_unit.sv -----
// Top level of the HSV dominant color counter.
// Uses hdcc_pkg, hdcc_front, hdcc_queue and hdcc_back.
//
// Usage:
//   pixel channel (pixel_valid / pixel_ready / pixel): one HSV pixel per
//   transfer with its row and a frame end mark. Pixels inside the row window
//   bump the counter of every color box they fall in (saturating).
//   result channel (result_valid / result_ready / result): one transfer per
//   frame, after the pixel marked frame_end, with all four counts, the first
//   strictly largest nonzero count and its detected flag. Counters then clear.
//   cfg port (cfg_we / cfg_index / cfg_data): writes the register cfg_index names;
//   write only while no frame is in flight.
// Throughput: one pixel per cycle, sustained, back to back frames included, while results are taken.
// Order: a frame end pixel is queued, then snapshotted, then its result is registered.
// Path: classifier (box compares), a four entry queue, counter update with
// frame snapshot, then winner search into the output register.
// Reset: counters clear, registers take their default boxes, window 60..180
// and threshold 500; the result channel goes idle.
// Stall: a stalled result holds; the snapshot keeps a frame and the counters
// and queue absorb pixels; pixel_ready drops only when the queue is full.
module hsv_dominant_color_counter_unit #(
	parameter int NUM_COLORS = hdcc_pkg::NUM_COLORS_DEF,
	parameter int COUNT_BITS = hdcc_pkg::COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pixel_valid,
	output logic                                pixel_ready,
	input  hdcc_pkg::pixel_t                    pixel,
	output logic                                result_valid,
	input  logic                                result_ready,
	output hdcc_pkg::result_t                   result,
	input  logic                                cfg_we,
	input  logic [hdcc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [hdcc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	hdcc_pkg::box_t box_q [hdcc_pkg::NUM_BOX_REGS];
	logic [7:0]     first_row_q;
	logic [7:0]     end_row_q;
	logic [15:0]    threshold_q;

	logic                  push;
	logic [NUM_COLORS-1:0] front_hits;
	logic                  front_last;
	logic                  queue_full;
	logic                  queue_valid;
	logic                  queue_pop;
	logic [NUM_COLORS:0]   queue_data;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q[0]    <= hdcc_pkg::BOX0_RESET;
			box_q[1]    <= hdcc_pkg::BOX1_RESET;
			box_q[2]    <= hdcc_pkg::BOX2_RESET;
			box_q[3]    <= hdcc_pkg::BOX3_RESET;
			first_row_q <= hdcc_pkg::FIRST_ROW_RESET;
			end_row_q   <= hdcc_pkg::END_ROW_RESET;
			threshold_q <= hdcc_pkg::THRESHOLD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index) inside
				hdcc_pkg::CFG_BOX0, hdcc_pkg::CFG_BOX1,
				hdcc_pkg::CFG_BOX2, hdcc_pkg::CFG_BOX3: begin
					box_q[cfg_index[hdcc_pkg::BOX_IDX_BITS-1:0]] <= cfg_data;
				end
				hdcc_pkg::CFG_FIRST_ROW: begin
					first_row_q <= cfg_data[7:0];
				end
				hdcc_pkg::CFG_END_ROW: begin
					end_row_q <= cfg_data[7:0];
				end
				hdcc_pkg::CFG_THRESHOLD: begin
					threshold_q <= cfg_data[15:0];
				end
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	hdcc_front #(
		.NUM_COLORS(NUM_COLORS)
	) u_front (
		.pixel       (pixel),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.boxes       (box_q),
		.first_row   (first_row_q),
		.end_row     (end_row_q),
		.queue_full  (queue_full),
		.push        (push),
		.hits        (front_hits),
		.frame_end   (front_last)
	);

	hdcc_queue #(
		.DATA_BITS(NUM_COLORS + 1),
		.DEPTH    (hdcc_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({front_last, front_hits}),
		.full      (queue_full),
		.valid     (queue_valid),
		.pop       (queue_pop),
		.pop_data  (queue_data)
	);

	hdcc_back #(
		.NUM_COLORS(NUM_COLORS),
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.queue_valid  (queue_valid),
		.queue_hits   (queue_data[NUM_COLORS-1:0]),
		.queue_last   (queue_data[NUM_COLORS]),
		.queue_pop    (queue_pop),
		.threshold    (threshold_q),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ----- rtl/hdcc_checker.sv -----
// Port level checks for the HSV dominant color counter, bound to the top.
// Depends on hdcc_pkg and hsv_dominant_color_counter_unit.
module hdcc_checker #(
	parameter int NUM_COLORS = hdcc_pkg::NUM_COLORS_DEF,
	parameter int COUNT_BITS = hdcc_pkg::COUNT_BITS_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_ready,
	input hdcc_pkg::result_t result
);

	// Field relations hold only while counts fit the output fields
	localparam bit FIELDS_EXACT = (NUM_COLORS <= 4) && (COUNT_BITS <= 16);

	// No result comes out of reset
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !result_valid)
		else $error("result_valid high during reset");

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// Winner count is the count of the named color
	a_winner_field: assert property (@(posedge clk) disable iff (!arst_n)
		FIELDS_EXACT && result_valid |->
			(result.winner != 2'd0 || result.winner_count == result.count_a) &&
			(result.winner != 2'd1 || result.winner_count == result.count_b) &&
			(result.winner != 2'd2 || result.winner_count == result.count_c) &&
			(result.winner != 2'd3 || result.winner_count == result.count_d))
		else $error("winner_count does not match the winning color");

	// Winner count is the largest
	a_winner_max: assert property (@(posedge clk) disable iff (!arst_n)
		FIELDS_EXACT && result_valid |->
			result.winner_count >= result.count_a &&
			result.winner_count >= result.count_b &&
			result.winner_count >= result.count_c &&
			result.winner_count >= result.count_d)
		else $error("winner_count below another count");

	// Detection needs a nonzero winner
	a_detect: assert property (@(posedge clk) disable iff (!arst_n)
		FIELDS_EXACT && result_valid && result.detected |->
			result.winner_count != 16'd0)
		else $error("detected with zero winner count");

endmodule

bind hsv_dominant_color_counter_unit hdcc_checker #(
	.NUM_COLORS(NUM_COLORS),
	.COUNT_BITS(COUNT_BITS)
) u_hdcc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
